### hw/rtl/bdee_pkg.sv
`default_nettype none

package bdee_pkg;

	// fixed field widths
	localparam int NUM_BUTTONS = 8;
	localparam int LEVEL_W     = 8;
	localparam int NOW_W       = 32;
	localparam int CODE_W      = 3;
	localparam int COUNT_W     = 32;
	localparam int DEBOUNCE_W  = 16;
	localparam int WINDOW_W    = 32;
	localparam int BTN_IDX_W   = $clog2(NUM_BUTTONS);

	// default time width of the internal timestamp arithmetic
	localparam int TIME_WIDTH  = 32;

	// button positions
	localparam int NUM_LETTERS = 5;
	localparam int BTN_ACCEPT  = 7;

	// apb register file
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;

	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd40;
	localparam logic [WINDOW_W-1:0]   WINDOW_RESET   = 32'd8000;

	typedef enum logic {
		REG_DEBOUNCE = 1'b0,
		REG_WINDOW   = 1'b1
	} reg_idx_t;

	typedef logic [NUM_BUTTONS-1:0] btn_mask_t;
	typedef logic [CODE_W-1:0]      code_t;

endpackage

`default_nettype wire

### hw/rtl/bdee_if.sv
`default_nettype none

// one poll of the raw button pins
interface bdee_poll_if;
	logic                         valid;
	logic                         ready;
	logic [bdee_pkg::LEVEL_W-1:0] raw_levels;
	logic [bdee_pkg::NOW_W-1:0]   now_ms;

	modport source (output valid, output raw_levels, output now_ms, input ready);
	modport sink   (input valid, input raw_levels, input now_ms, output ready);
endinterface

// one encoded button event
interface bdee_event_if;
	logic                         valid;
	logic                         ready;
	logic [bdee_pkg::CODE_W-1:0]  event_code;
	logic [bdee_pkg::COUNT_W-1:0] event_number;
	logic                         last_event;

	modport source (output valid, output event_code, output event_number,
		output last_event, input ready);
	modport sink   (input valid, input event_code, input event_number,
		input last_event, output ready);
endinterface

`default_nettype wire

### hw/rtl/bdee_debounce.sv
`default_nettype none

module bdee_debounce #(
	parameter int TIME_WIDTH = bdee_pkg::TIME_WIDTH
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  advance,
	input  wire  [bdee_pkg::LEVEL_W-1:0]         levels,
	input  wire  [TIME_WIDTH-1:0]                now,
	input  wire  [bdee_pkg::DEBOUNCE_W-1:0]      debounce_time,
	output bdee_pkg::btn_mask_t                  press
);

	bdee_pkg::btn_mask_t  prev_q;
	bdee_pkg::btn_mask_t  stable_q;
	logic [TIME_WIDTH-1:0] change_time_q [bdee_pkg::NUM_BUTTONS];

	logic [TIME_WIDTH-1:0] change_time_nxt [bdee_pkg::NUM_BUTTONS];
	logic [TIME_WIDTH-1:0] elapsed [bdee_pkg::NUM_BUTTONS];
	bdee_pkg::btn_mask_t   settle;

	// one lane per button: restart timer on change, settle after quiet period
	always_comb begin
		for (int i = 0; i < bdee_pkg::NUM_BUTTONS; i++) begin
			change_time_nxt[i] = (levels[i] != prev_q[i]) ? now : change_time_q[i];
			elapsed[i] = now - change_time_nxt[i];
			settle[i] = (elapsed[i] > TIME_WIDTH'(debounce_time)) &&
				(levels[i] != stable_q[i]);
			press[i] = settle[i] & ~levels[i];
		end
	end

	// lane state, updated once per poll
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= '1;
			stable_q <= '1;
			for (int i = 0; i < bdee_pkg::NUM_BUTTONS; i++) begin
				change_time_q[i] <= '0;
			end
		end else if (advance) begin
			prev_q <= levels;
			for (int i = 0; i < bdee_pkg::NUM_BUTTONS; i++) begin
				change_time_q[i] <= change_time_nxt[i];
				if (settle[i]) begin
					stable_q[i] <= levels[i];
				end
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/button_debounce_event_encoder.sv
// Eight-button debouncer and event encoder.
//
// poll (sink): one transaction per poll, carrying the eight raw active-low
// pin levels (A..E, START, CANCEL, ACCEPT) and a millisecond timestamp.
// events (source): one transaction per event, in button order, with the code,
// the running event number and a flag on the last event of its poll.
// APB port: register 0 debounce_time at 0x0, register 1 accept_window at 0x4.
//
// Path: input register, debounce lanes, serializer mask, output register.
// A poll that yields n events (up to eight) holds the event serializer
// until all are sent, one event per cycle while events.ready allows; polls
// that yield no event pass at one per cycle once the serializer is empty.
// A new poll is taken while earlier events are still draining.
// Reset: all buttons read released, no letter chosen, event count zero,
// registers at 40 ms and 8000 ms.
// Stall: when events.ready is low the output register holds its event and
// the serializer and poll input back up; nothing is dropped.
`default_nettype none

module button_debounce_event_encoder #(
	parameter int TIME_WIDTH = bdee_pkg::TIME_WIDTH
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                psel,
	input  wire                                penable,
	input  wire                                pwrite,
	input  wire  [bdee_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire  [bdee_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [bdee_pkg::APB_DATA_W-1:0]    prdata,
	output logic                               pready,
	bdee_poll_if.sink                          poll,
	bdee_event_if.source                       events
);

	localparam int CMP_W = (TIME_WIDTH > bdee_pkg::WINDOW_W) ? TIME_WIDTH
		: bdee_pkg::WINDOW_W;

	// configuration registers
	logic [bdee_pkg::DEBOUNCE_W-1:0] debounce_q;
	logic [bdee_pkg::WINDOW_W-1:0]   window_q;
	bdee_pkg::reg_idx_t              reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = bdee_pkg::reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= bdee_pkg::DEBOUNCE_RESET;
			window_q   <= bdee_pkg::WINDOW_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				bdee_pkg::REG_DEBOUNCE: debounce_q <= pwdata[bdee_pkg::DEBOUNCE_W-1:0];
				bdee_pkg::REG_WINDOW:   window_q   <= pwdata[bdee_pkg::WINDOW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			bdee_pkg::REG_DEBOUNCE: prdata = bdee_pkg::APB_DATA_W'(debounce_q);
			bdee_pkg::REG_WINDOW:   prdata = bdee_pkg::APB_DATA_W'(window_q);
			default:                prdata = '0;
		endcase
	end

	// input register
	logic                           valid_s1;
	logic [bdee_pkg::LEVEL_W-1:0]   levels_s1;
	logic [bdee_pkg::NOW_W-1:0]     now_s1;
	logic                           advance;

	assign poll.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.valid && poll.ready) begin
			levels_s1 <= poll.raw_levels;
			now_s1    <= poll.now_ms;
		end
	end

	// debounce lanes
	logic [TIME_WIDTH-1:0] now_t;
	bdee_pkg::btn_mask_t   press;

	assign now_t = TIME_WIDTH'(now_s1);

	bdee_debounce #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_debounce (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.levels        (levels_s1),
		.now           (now_t),
		.debounce_time (debounce_q),
		.press         (press)
	);

	// letter memory and accept check
	bdee_pkg::code_t              chosen_q;
	logic                         letter_valid_q;
	logic [TIME_WIDTH-1:0]        letter_time_q;
	logic [bdee_pkg::COUNT_W-1:0] count_q;

	logic                         any_letter;
	bdee_pkg::code_t              new_letter;
	logic [TIME_WIDTH-1:0]        since;
	logic                         accept_ok;
	bdee_pkg::code_t              accept_code;
	bdee_pkg::btn_mask_t          mask_new;

	always_comb begin
		any_letter = |press[bdee_pkg::NUM_LETTERS-1:0];
		new_letter = '0;
		for (int i = 0; i < bdee_pkg::NUM_LETTERS; i++) begin
			if (press[i]) begin
				new_letter = bdee_pkg::CODE_W'(i);
			end
		end
		since       = now_t - letter_time_q;
		accept_ok   = press[bdee_pkg::BTN_ACCEPT] && (any_letter ||
			(letter_valid_q && (CMP_W'(since) <= CMP_W'(window_q))));
		accept_code = any_letter ? new_letter : chosen_q;
		mask_new    = press;
		mask_new[bdee_pkg::BTN_ACCEPT] = accept_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chosen_q       <= '0;
			letter_valid_q <= 1'b0;
			letter_time_q  <= '0;
			count_q        <= '0;
		end else if (advance) begin
			if (any_letter) begin
				chosen_q       <= new_letter;
				letter_valid_q <= 1'b1;
				letter_time_q  <= now_t;
			end
			count_q <= count_q + bdee_pkg::COUNT_W'($countones(mask_new));
		end
	end

	// event serializer: pending mask drained lowest button first
	bdee_pkg::btn_mask_t          mask_s2;
	bdee_pkg::code_t              accept_code_s2;
	logic [bdee_pkg::COUNT_W-1:0] base_s2;

	bdee_pkg::btn_mask_t          mask_rest;
	logic [bdee_pkg::BTN_IDX_W-1:0] pick;
	bdee_pkg::code_t              pick_code;
	logic                         out_valid_q;
	logic                         emit;

	always_comb begin
		pick = '0;
		for (int i = bdee_pkg::NUM_BUTTONS - 1; i >= 0; i--) begin
			if (mask_s2[i]) begin
				pick = bdee_pkg::BTN_IDX_W'(i);
			end
		end
		pick_code = (pick == bdee_pkg::BTN_IDX_W'(bdee_pkg::BTN_ACCEPT)) ? accept_code_s2
			: bdee_pkg::CODE_W'(pick);
		mask_rest = mask_s2 & (mask_s2 - bdee_pkg::btn_mask_t'(1));
	end

	assign emit    = (|mask_s2) && (!out_valid_q || events.ready);
	assign advance = valid_s1 && ((mask_s2 == '0) || (emit && (mask_rest == '0)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s2 <= '0;
		end else if (advance) begin
			mask_s2 <= mask_new;
		end else if (emit) begin
			mask_s2 <= mask_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			accept_code_s2 <= accept_code;
			base_s2        <= count_q;
		end else if (emit) begin
			base_s2 <= base_s2 + 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (events.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			events.event_code   <= pick_code;
			events.event_number <= base_s2 + 1'b1;
			events.last_event   <= (mask_rest == '0);
		end
	end

	assign events.valid = out_valid_q;

endmodule

`default_nettype wire

### test/button_debounce_event_encoder_tb.sv
`timescale 1ns / 100ps

module button_debounce_event_encoder_tb;
	import bdee_pkg::*;

	// event codes and button positions not named in the package
	localparam code_t CODE_START  = 3'd5;
	localparam code_t CODE_CANCEL = 3'd6;
	localparam int    START_PIN   = 5;
	localparam int    CANCEL_PIN  = 6;

	localparam int LONG_HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES    = 12;

	typedef struct {
		code_t              code;
		logic [COUNT_W-1:0] number;
		logic               last;
	} button_event_t;

	// tracks debounce state and holds the events each poll should produce
	class event_ledger;
		logic [DEBOUNCE_W-1:0] debounce;
		logic [WINDOW_W-1:0]   window;
		btn_mask_t             stable;
		btn_mask_t             prev_read;
		logic [NOW_W-1:0]      change_ms [NUM_BUTTONS];
		code_t                 chosen;
		logic                  chosen_valid;
		logic [NOW_W-1:0]      chosen_ms;
		logic [COUNT_W-1:0]    event_total;
		button_event_t         due_events [$];
		int                    errors;

		function new();
			debounce     = DEBOUNCE_RESET;
			window       = WINDOW_RESET;
			stable       = '1;
			prev_read    = '1;
			foreach (change_ms[b]) change_ms[b] = '0;
			chosen       = '0;
			chosen_valid = 1'b0;
			chosen_ms    = '0;
			event_total  = '0;
			errors       = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
			if (idx == REG_DEBOUNCE) debounce = value[DEBOUNCE_W-1:0];
			else window = value[WINDOW_W-1:0];
		endfunction

		function int pending();
			return due_events.size();
		endfunction

		// work out the events of one accepted poll transaction
		function void note_poll(btn_mask_t levels, logic [NOW_W-1:0] now_ms);
			button_event_t    batch [$];
			button_event_t    ev;
			logic [NOW_W-1:0] held_for;
			logic [NOW_W-1:0] since;
			logic             fire;
			for (int b = 0; b < NUM_BUTTONS; b++) begin
				fire = 1'b0;
				if (levels[b] != prev_read[b]) begin
					prev_read[b] = levels[b];
					change_ms[b] = now_ms;
				end
				held_for = now_ms - change_ms[b];
				if (held_for > NOW_W'(debounce) && levels[b] != stable[b]) begin
					stable[b] = levels[b];
					// only a press emits; a release just updates the stable level
					if (!levels[b]) begin
						if (b < NUM_LETTERS) begin
							chosen       = code_t'(b);
							chosen_valid = 1'b1;
							chosen_ms    = now_ms;
							ev.code      = code_t'(b);
							fire         = 1'b1;
						end else if (b == START_PIN) begin
							ev.code = CODE_START;
							fire    = 1'b1;
						end else if (b == CANCEL_PIN) begin
							ev.code = CODE_CANCEL;
							fire    = 1'b1;
						end else if (b == BTN_ACCEPT) begin
							since = now_ms - chosen_ms;
							if (chosen_valid && since <= NOW_W'(window)) begin
								ev.code = chosen;
								fire    = 1'b1;
							end
						end
					end
				end
				if (fire) begin
					event_total = event_total + 1;
					ev.number   = event_total;
					ev.last     = 1'b0;
					batch.push_back(ev);
				end
			end
			if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
			foreach (batch[k]) due_events.push_back(batch[k]);
		endfunction

		// compare one accepted event transaction with the oldest expected one
		function void check_event(code_t code, logic [COUNT_W-1:0] number, logic last);
			button_event_t ev;
			if (due_events.size() == 0) begin
				$error("unexpected event: code %0d number %0d last %0d", code, number, last);
				errors++;
				return;
			end
			ev = due_events.pop_front();
			if (code !== ev.code) begin
				$error("event_code: expected %0d, got %0d", ev.code, code);
				errors++;
			end
			if (number !== ev.number) begin
				$error("event_number: expected %0d, got %0d", ev.number, number);
				errors++;
			end
			if (last !== ev.last) begin
				$error("last_event: expected %0d, got %0d", ev.last, last);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	bdee_poll_if  poll_ch ();
	bdee_event_if event_ch ();

	event_ledger      sb;
	bit               idle_on;
	bit               long_hold_req;
	btn_mask_t        pins;
	logic [NOW_W-1:0] clock_ms;

	button_debounce_event_encoder i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.poll    (poll_ch),
		.events  (event_ch)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

	// event receiver with random stalls and an occasional long hold-off
	initial begin
		int hold_left;
		hold_left = 0;
		event_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (event_ch.valid && event_ch.ready)
				sb.check_event(event_ch.event_code, event_ch.event_number, event_ch.last_event);
			if (hold_left > 0) begin
				hold_left--;
				event_ch.ready <= 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD_CYCLES - 1;
				event_ch.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				hold_left = $urandom_range(1, 14) - 1;
				event_ch.ready <= 1'b0;
			end else begin
				event_ch.ready <= 1'b1;
			end
		end
	end

	// offer one poll transaction, with an optional idle burst ahead of it
	task automatic send_poll(input btn_mask_t levels, input logic [NOW_W-1:0] now_ms);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			poll_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		poll_ch.valid      <= 1'b1;
		poll_ch.raw_levels <= levels;
		poll_ch.now_ms     <= now_ms;
		do @(posedge clk); while (!poll_ch.ready);
		sb.note_poll(levels, now_ms);
	endtask

	// stop offering and wait for every expected event, then let the block settle
	task automatic wait_drained(input int settle);
		poll_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic configure(input logic [DEBOUNCE_W-1:0] deb, input logic [WINDOW_W-1:0] win);
		wait_drained(SETTLE_CYCLES);
		apb_write(REG_DEBOUNCE, APB_DATA_W'(deb));
		apb_write(REG_WINDOW, win);
		clock_ms = $urandom;
		pins = '1;
	endtask

	// press/hold/release sequences with bounce, plus some noise and time jumps
	task automatic run_random_polls(input int count);
		int               kind;
		int               btn;
		logic [NOW_W-1:0] step;
		for (int k = 0; k < count; k++) begin
			kind = $urandom_range(0, 9);
			if (kind < 5) begin
				btn = $urandom_range(0, NUM_BUTTONS - 1);
				pins[btn] = ~pins[btn];
			end else if (kind == 5) begin
				pins = btn_mask_t'($urandom);
			end
			kind = $urandom_range(0, 9);
			if (kind < 6)
				step = NOW_W'(sb.debounce) + 1 + NOW_W'($urandom_range(0, 30));
			else if (kind < 8)
				step = NOW_W'($urandom_range(0, sb.debounce));
			else if (kind == 8)
				step = $urandom;
			else
				step = '0;
			clock_ms = clock_ms + step;
			send_poll(pins, clock_ms);
		end
	endtask

	// directed polls at the reset settings of 40 ms and 8000 ms
	task automatic run_directed();
		// accept with no letter chosen
		send_poll(8'h7F, 0);
		send_poll(8'h7F, 41);
		send_poll(8'hFF, 50);
		send_poll(8'hFF, 91);
		// letter A, steady for exactly the debounce time and then one more
		send_poll(8'hFE, 100);
		send_poll(8'hFE, 140);
		send_poll(8'hFE, 141);
		send_poll(8'hFF, 150);
		send_poll(8'hFF, 191);
		// every button at once, accept re-emits E
		send_poll(8'h00, 200);
		send_poll(8'h00, 241);
		send_poll(8'hFF, 300);
		send_poll(8'hFF, 341);
		// accept long after the letter
		send_poll(8'h7F, 9000);
		send_poll(8'h7F, 9041);
		// timestamp going backwards
		send_poll(8'hFD, 20000);
		send_poll(8'hFD, 5);
		send_poll(8'hFF, 6);
		send_poll(8'hFF, 100);
		// timestamp wrapping, then accept inside the window
		send_poll(8'hFE, 32'hFFFF_FFF0);
		send_poll(8'hFE, 32'h0000_0020);
		send_poll(8'h7E, 32'h0000_0030);
		send_poll(8'h7E, 32'h0000_0059);
		send_poll(8'hFF, 32'h0000_0060);
		send_poll(8'hFF, 32'h0000_0100);
	endtask

	// main sequence
	initial begin
		sb                 = new();
		idle_on            = 1'b1;
		long_hold_req      = 1'b0;
		pins               = '1;
		clock_ms           = 32'h0000_0200;
		arst_n             <= 1'b0;
		psel               <= 1'b0;
		penable            <= 1'b0;
		pwrite             <= 1'b0;
		paddr              <= '0;
		pwdata             <= '0;
		poll_ch.valid      <= 1'b0;
		poll_ch.raw_levels <= '1;
		poll_ch.now_ms     <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_random_polls(24);

		// shortest debounce, zero window, receiver holds off while polls keep coming
		configure(16'd0, 32'd0);
		long_hold_req = 1'b1;
		run_random_polls(24);

		// longest debounce and window
		configure(16'hFFFF, 32'hFFFF_FFFF);
		run_random_polls(24);

		// random middle settings, with a full drain halfway
		configure(DEBOUNCE_W'($urandom_range(1, 60)), WINDOW_W'($urandom_range(50, 400)));
		run_random_polls(12);
		wait_drained(0);
		run_random_polls(12);

		// last stretch at full rate
		configure(16'd5, 32'd1000);
		idle_on = 1'b0;
		run_random_polls(10);

		wait_drained(SETTLE_CYCLES + 8);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
